// ===== hdl/ggm_pkg.sv =====
`default_nettype none
package ggm_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_WAIT,
        ST_OUT_HI,
        ST_OUT_LO
    } t_state;

    localparam int unsigned CFG_KEY_HIGH = 0;
    localparam int unsigned CFG_KEY_LOW  = 1;
    localparam int unsigned CFG_SYM_LOG2 = 2;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction
endpackage
`default_nettype wire

// ===== hdl/ggm_tree_aes_prf.sv =====
`default_nettype none
// GGM-tree PRF over AES-128. Each accepted byte is split into symbols of
// 1, 2, 4 or 8 bits (msb first). Each symbol is shifted in bit by bit,
// replicated across the byte by repeated doubling and encrypted as a
// 128-bit block under the running key on the round-per-cycle core; the
// result becomes the new running key. A final transaction then encrypts a
// zero block for whitening and delivers two 64-bit halves, high half first,
// each held until taken. The key registers reload the running key between
// messages; write configuration only while idle.
module ggm_tree_aes_prf
    import ggm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_final_req,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_tag_half,
    output logic             o_last_result
);
    t_state r_st, n_st;
    logic [63:0]  r_key_hi, r_key_lo;
    logic [1:0]   r_sym_log2;
    logic [127:0] r_rkey, n_rkey;
    logic         r_busy, n_busy;
    logic [7:0]   r_shift, n_shift;
    logic [7:0]   r_sym, n_sym;
    logic [3:0]   r_cnt, n_cnt;
    logic [3:0]   r_left, n_left;
    logic         r_final, n_final;
    logic         r_whiten, n_whiten;
    logic [63:0]  r_lo_half, n_lo_half;
    logic         s_start;
    logic [127:0] s_block;
    logic         s_done;
    logic [127:0] s_result;
    logic [3:0]   s_width;

    assign s_width = 4'd1 << r_sym_log2;

    ggm_aes_core u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_start),
        .i_key    (r_rkey),
        .i_block  (s_block),
        .o_done   (s_done),
        .o_result (s_result)
    );

    assign s_block = r_whiten ? 128'd0 : {16{r_sym}};

    always_comb begin
        n_st      = r_st;
        n_rkey    = r_rkey;
        n_busy    = r_busy;
        n_shift   = r_shift;
        n_sym     = r_sym;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_final   = r_final;
        n_whiten  = r_whiten;
        n_lo_half = r_lo_half;
        s_start   = 1'b0;
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        o_tag_half    = s_result[127:64];
        o_last_result = 1'b0;
        case (r_st)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (!r_busy) begin
                    n_rkey = {r_key_hi, r_key_lo};
                end
                if (i_valid) begin
                    n_shift = i_data_byte;
                    n_final = i_final_req;
                    n_left  = 4'd8 >> r_sym_log2;
                    n_cnt   = 4'd0;
                    n_sym   = 8'd0;
                    if (i_byte_present) begin
                        n_whiten = 1'b0;
                        n_busy   = 1'b1;
                        n_st     = ST_LOAD;
                    end else if (i_final_req) begin
                        n_whiten = 1'b1;
                        n_st     = ST_RUN;
                    end
                end
            end
            ST_LOAD: begin
                // gather one symbol bit per cycle, msb of the byte first
                n_sym   = {r_sym[6:0], r_shift[7]};
                n_shift = {r_shift[6:0], 1'b0};
                n_cnt   = r_cnt + 4'd1;
                if (r_cnt + 4'd1 == s_width) begin
                    n_cnt = s_width;
                    n_st  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!r_whiten && r_cnt != 4'd8) begin
                    // double the replicated span until it fills the byte
                    n_sym = (r_sym << r_cnt) | r_sym;
                    n_cnt = r_cnt << 1;
                end else begin
                    s_start = 1'b1;
                    n_st    = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (s_done) begin
                    if (r_whiten) begin
                        n_lo_half = s_result[63:0];
                        n_st      = ST_OUT_HI;
                    end else begin
                        n_rkey = s_result;
                        n_left = r_left - 4'd1;
                        n_cnt  = 4'd0;
                        n_sym  = 8'd0;
                        if (r_left != 4'd1) begin
                            n_st = ST_LOAD;
                        end else if (r_final) begin
                            n_rkey   = s_result;
                            n_whiten = 1'b1;
                            n_st     = ST_RUN;
                        end else begin
                            n_st = ST_IDLE;
                        end
                    end
                end
            end
            ST_OUT_HI: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_st = ST_OUT_LO;
                end
            end
            ST_OUT_LO: begin
                o_valid       = 1'b1;
                o_tag_half    = r_lo_half;
                o_last_result = 1'b1;
                if (i_ready) begin
                    n_busy   = 1'b0;
                    n_whiten = 1'b0;
                    n_rkey   = {r_key_hi, r_key_lo};
                    n_st     = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rkey    <= n_rkey;
        r_shift   <= n_shift;
        r_sym     <= n_sym;
        r_cnt     <= n_cnt;
        r_left    <= n_left;
        r_final   <= n_final;
        r_lo_half <= n_lo_half;
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_busy     <= 1'b0;
            r_whiten   <= 1'b0;
            r_key_hi   <= 64'd0;
            r_key_lo   <= 64'd0;
            r_sym_log2 <= 2'd0;
        end else begin
            r_st     <= n_st;
            r_busy   <= n_busy;
            r_whiten <= n_whiten;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    2'(CFG_KEY_HIGH): r_key_hi   <= i_cfg_data;
                    2'(CFG_KEY_LOW):  r_key_lo   <= i_cfg_data;
                    2'(CFG_SYM_LOG2): r_sym_log2 <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ggm_aes_core.sv =====
`default_nettype none
module ggm_aes_core
    import ggm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_key,
    input  wire logic [127:0] i_block,
    output logic              o_done,
    output logic [127:0]      o_result
);
    // one aes round per cycle, round key expanded on the fly
    logic [127:0] r_state, n_state;
    logic [127:0] r_rkey, n_rkey;
    logic [7:0]   r_rcon, n_rcon;
    logic [3:0]   r_round, n_round;
    logic         r_busy, n_busy;
    logic         r_done, n_done;

    logic [7:0]   s_in [16];
    logic [7:0]   s_sub [16];
    logic [7:0]   s_mix [16];
    logic [127:0] s_round;
    logic [127:0] s_next_key;
    logic [31:0]  s_rot;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s_in[i] = r_state[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                s_sub[c*4 + row] = sbox(s_in[((c + row) % 4)*4 + row]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, all;
            a0 = s_sub[c*4];
            a1 = s_sub[c*4 + 1];
            a2 = s_sub[c*4 + 2];
            a3 = s_sub[c*4 + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (r_round == 4'd10) begin
                s_mix[c*4] = a0;
                s_mix[c*4 + 1] = a1;
                s_mix[c*4 + 2] = a2;
                s_mix[c*4 + 3] = a3;
            end else begin
                s_mix[c*4] = a0 ^ all ^ xtime(a0 ^ a1);
                s_mix[c*4 + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                s_mix[c*4 + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                s_mix[c*4 + 3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        s_rot = {sbox(r_rkey[23:16]) ^ r_rcon, sbox(r_rkey[15:8]), sbox(r_rkey[7:0]),
                 sbox(r_rkey[31:24])};
        s_next_key[127:96] = r_rkey[127:96] ^ s_rot;
        s_next_key[95:64]  = r_rkey[95:64] ^ s_next_key[127:96];
        s_next_key[63:32]  = r_rkey[63:32] ^ s_next_key[95:64];
        s_next_key[31:0]   = r_rkey[31:0] ^ s_next_key[63:32];
        for (int i = 0; i < 16; i++) begin
            s_round[127 - 8*i -: 8] = s_mix[i] ^ s_next_key[127 - 8*i -: 8];
        end
    end

    always_comb begin
        n_state = r_state;
        n_rkey  = r_rkey;
        n_rcon  = r_rcon;
        n_round = r_round;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_state = i_block ^ i_key;
            n_rkey  = i_key;
            n_rcon  = 8'h01;
            n_round = 4'd1;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_state = s_round;
            n_rkey  = s_next_key;
            n_rcon  = xtime(r_rcon);
            n_round = r_round + 4'd1;
            if (r_round == 4'd10) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_rkey  <= n_rkey;
        r_rcon  <= n_rcon;
        r_round <= n_round;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_state;
endmodule
`default_nettype wire

// ===== test/tb_ggm_tree_aes_prf.sv =====
`default_nettype none
module tb_ggm_tree_aes_prf
    import ggm_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_final_req;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_tag_half;
    logic        o_last_result;

    ggm_tree_aes_prf DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data_byte(i_data_byte),
        .i_byte_present(i_byte_present),
        .i_final_req(i_final_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_tag_half(o_tag_half),
        .o_last_result(o_last_result)
    );

    typedef struct packed {
        logic [63:0] tag;
        logic        last;
    } t_half;

    typedef struct {
        logic [7:0]  data;
        logic        present;
        logic        fin;
        logic        known;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_row;

    localparam int NUM_ROWS = 12;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 200;

    logic [63:0] key_hi_reg;
    logic [63:0] key_lo_reg;
    logic [1:0]  sym_log2_reg;
    logic [127:0] chain_key;
    logic        absorbing;
    t_half       tag_queue[$];
    int          error_count;
    bit          stall_enable;
    t_row        rows[NUM_ROWS];

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #8000000;
        $display("ggm_tree_aes_prf regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [7:0] sb(input logic [7:0] a);
        logic [7:0] tbl [256];
        tbl = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tbl[a];
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte 0 of a block sits in bits 127:120
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] blk);
        logic [7:0] rk[176];
        logic [7:0] s[16];
        logic [7:0] t[16];
        logic [7:0] w[4];
        logic [7:0] tmp, rc, all;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) rk[i] = key[127 - 8*i -: 8];
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
            if ((i % 16) == 0) begin
                tmp = w[0];
                w[0] = sb(w[1]) ^ rc;
                w[1] = sb(w[2]);
                w[2] = sb(w[3]);
                w[3] = sb(tmp);
                rc = dbl(rc);
            end
            for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
        end
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    t[c*4 + row] = sb(s[((c + row) % 4)*4 + row]);
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    for (int j = 0; j < 4; j++) w[j] = t[c*4 + j];
                    all = w[0] ^ w[1] ^ w[2] ^ w[3];
                    for (int j = 0; j < 4; j++)
                        t[c*4 + j] = w[j] ^ all ^ dbl(w[j] ^ w[(j + 1) % 4]);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r*16 + i];
        end
        for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
        return res;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_KEY_HIGH: key_hi_reg = val;
            CFG_KEY_LOW:  key_lo_reg = val;
            default:      sym_log2_reg = val[1:0];
        endcase
        if (!absorbing) chain_key = {key_hi_reg, key_lo_reg};
    endtask

    // advances the tree state; returns the tag on a final transaction
    task automatic absorb_item(input logic [7:0] data, input logic present,
                               input logic fin, output logic [127:0] tag);
        int width;
        logic [7:0] sym, rep;
        tag = '0;
        if (!absorbing) chain_key = {key_hi_reg, key_lo_reg};
        if (present) begin
            width = 1 << sym_log2_reg;
            for (int pos = 0; pos < 8; pos += width) begin
                sym = 8'((data >> (8 - pos - width)) & ((9'd1 << width) - 9'd1));
                rep = '0;
                for (int j = 0; j < 8; j += width) rep |= sym << j;
                chain_key = aes_encrypt(chain_key, {16{rep}});
            end
            absorbing = 1'b1;
        end
        if (fin) begin
            tag = aes_encrypt(chain_key, '0);
            absorbing = 1'b0;
            chain_key = {key_hi_reg, key_lo_reg};
        end
    endtask

    task automatic send_item(input logic [7:0] data, input logic present,
                             input logic fin, input logic known,
                             input logic [127:0] typed);
        logic [127:0] tag;
        int gap;
        gap = 0;
        if (!stall_enable || $urandom_range(0, 3) == 0) gap = $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        absorb_item(data, present, fin, tag);
        if (fin) begin
            if (known) tag = typed;
            tag_queue.push_back({tag[127:64], 1'b0});
            tag_queue.push_back({tag[63:0], 1'b1});
        end
        i_valid        <= 1'b1;
        i_data_byte    <= data;
        i_byte_present <= present;
        i_final_req    <= fin;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        while (tag_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!stall_enable) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 9) < 6);
    end

    always @(posedge i_clk) begin
        t_half want;
        if (i_rst_n && o_valid && i_ready) begin
            if (tag_queue.size() == 0) begin
                report_mismatch("unexpected transaction", o_tag_half, '0);
            end else begin
                want = tag_queue.pop_front();
                if (o_tag_half !== want.tag) report_mismatch("tag_half", o_tag_half, want.tag);
                if (o_last_result !== want.last)
                    report_mismatch("last_result", o_last_result, want.last);
            end
        end
    end

    initial begin
        logic [7:0] data;
        logic pres, fin;
        int msg_len;
        error_count  = 0;
        stall_enable = 0;
        key_hi_reg   = '0;
        key_lo_reg   = '0;
        sym_log2_reg = '0;
        absorbing    = 0;
        chain_key    = '0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 0; i_data_byte = '0; i_byte_present = 0; i_final_req = 0;
        i_ready = 1;
        rows[0]  = '{8'h00, 1'b0, 1'b1, 1'b1,
                     64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
        rows[1]  = '{8'h00, 1'b0, 1'b0, 1'b0, '0, '0};
        rows[2]  = '{8'h00, 1'b1, 1'b1, 1'b0, '0, '0};
        rows[3]  = '{8'hff, 1'b1, 1'b1, 1'b0, '0, '0};
        rows[4]  = '{8'ha5, 1'b1, 1'b0, 1'b0, '0, '0};
        rows[5]  = '{8'h00, 1'b0, 1'b0, 1'b0, '0, '0};
        rows[6]  = '{8'h5a, 1'b1, 1'b0, 1'b0, '0, '0};
        rows[7]  = '{8'h00, 1'b0, 1'b1, 1'b0, '0, '0};
        rows[8]  = '{8'h80, 1'b1, 1'b0, 1'b0, '0, '0};
        rows[9]  = '{8'h01, 1'b1, 1'b1, 1'b0, '0, '0};
        rows[10] = '{8'h00, 1'b0, 1'b1, 1'b1,
                     64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
        rows[11] = '{8'h7e, 1'b1, 1'b1, 1'b0, '0, '0};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        for (int s = 0; s < 4; s++) begin
            if (s > 0) write_reg(2'(CFG_SYM_LOG2), 64'(s));
            for (int r = 0; r < NUM_ROWS; r++)
                send_item(rows[r].data, rows[r].present, rows[r].fin,
                          rows[r].known && s == 0, {rows[r].hi, rows[r].lo});
            wait_drained();
        end

        stall_enable = 1;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(2'(CFG_KEY_HIGH), '1);
                    write_reg(2'(CFG_KEY_LOW), '1);
                end
                1: begin
                    write_reg(2'(CFG_KEY_HIGH), '0);
                    write_reg(2'(CFG_KEY_LOW), '1);
                end
                default: begin
                    write_reg(2'(CFG_KEY_HIGH), {$urandom, $urandom});
                    write_reg(2'(CFG_KEY_LOW), {$urandom, $urandom});
                end
            endcase
            write_reg(2'(CFG_SYM_LOG2), 64'(phase % 4));
            for (int n = 0; n < RANDOM_ITEMS / 8; ) begin
                msg_len = $urandom_range(0, 4);
                for (int b = 0; b <= msg_len; b++) begin
                    data = 8'($urandom);
                    pres = ($urandom_range(0, 9) != 0);
                    fin  = (b == msg_len);
                    if (b == 0 && fin && $urandom_range(0, 3) == 0) pres = 0;
                    send_item(data, pres, fin, 1'b0, '0);
                    if (pres || fin) n++;
                end
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("ggm_tree_aes_prf regression: pass");
        end else begin
            $display("ggm_tree_aes_prf regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/ggm_pkg.sv
hdl/ggm_aes_core.sv
hdl/ggm_tree_aes_prf.sv
test/tb_ggm_tree_aes_prf.sv
